@@ rtl/dlte_pkg.sv @@
// Package for the double-logistic temperature effect core.
// Holds beat types, pipeline latencies and the constant root table function.
// No dependencies.
package dlte_pkg;

  typedef struct packed {
    logic signed [15:0] temperature_c;
    logic        [5:0]  species_index;
    logic signed [15:0] low_floor;
    logic        [15:0] low_midpoint;
    logic signed [15:0] low_steepness;
    logic signed [15:0] high_floor;
    logic        [15:0] high_midpoint;
    logic signed [15:0] high_steepness;
  } dlte_in_t;

  typedef struct packed {
    logic [15:0] effect;
    logic [5:0]  species_out;
    logic        status;
  } dlte_out_t;

  localparam int LOG_LAT   = 17;
  localparam int FRAC_LAT  = 50;
  localparam int COEF_LAT  = LOG_LAT + 1;
  localparam int FLOOR_LAT = COEF_LAT + FRAC_LAT;
  localparam int PIPE_LAT  = FLOOR_LAT + 4;
  localparam int TAG_LAT   = PIPE_LAT - 1;

  localparam logic signed [17:0] KELVIN_Q8 = 18'sd69926;
  localparam logic [15:0]        EFFECT_MAX = 16'd32768;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_m;
    logic [63:0] rem;
    res   = '0;
    rem   = v;
    bit_m = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bit_m) begin
        rem = rem - (res + bit_m);
        res = (res >> 1) + bit_m;
      end else begin
        res = res >> 1;
      end
      bit_m = bit_m >> 2;
    end
    return res;
  endfunction

  // 2^(2^-(k+1)) in Q.30
  function automatic logic [30:0] exp_root(input int k);
    logic [63:0] root;
    root = isqrt64(64'h2000_0000_0000_0000);
    for (int j = 0; j < k; j++) begin
      root = isqrt64(root << 30);
    end
    return root[30:0];
  endfunction

endpackage

@@ rtl/dlte_log2.sv @@
// Pipelined log2 of a 17 bit positive integer, Q.16 result.
// One normalize stage and sixteen squaring stages. Uses dlte_pkg.
module dlte_log2 import dlte_pkg::*; (
  input  logic        clk,
  input  logic [16:0] v,
  output logic [20:0] lg
);

  logic [4:0]  e_s [17];
  logic [31:0] m_s [17];
  logic [15:0] f_s [17];
  logic [4:0]  e_in;
  logic [31:0] m_in;

  always_comb begin
    e_in = '0;
    for (int i = 0; i < 17; i++) begin
      if (v[i]) e_in = 5'(i);
    end
    m_in = 32'({15'b0, v} << (5'd31 - e_in));
  end

  always_ff @(posedge clk) begin
    e_s[0] <= e_in;
    m_s[0] <= m_in;
    f_s[0] <= '0;
  end

  for (genvar k = 0; k < 16; k++) begin : g_sq
    logic [63:0] sq;
    assign sq = 64'(m_s[k]) * 64'(m_s[k]);
    always_ff @(posedge clk) begin
      e_s[k+1] <= e_s[k];
      if (sq[63]) begin
        m_s[k+1] <= sq[63:32];
        f_s[k+1] <= {f_s[k][14:0], 1'b1};
      end else begin
        m_s[k+1] <= sq[62:31];
        f_s[k+1] <= {f_s[k][14:0], 1'b0};
      end
    end
  end

  assign lg = {e_s[16], f_s[16]};

endmodule

@@ rtl/dlte_frac.sv @@
// Pipelined logistic fraction 1 / (1 + 2^(c*d)) in Q.30.
// Exponent multiply, sixteen root stages, shift, 31 restoring divide stages.
// Uses dlte_pkg.
module dlte_frac import dlte_pkg::*; (
  input  logic               clk,
  input  logic signed [15:0] steep,
  input  logic signed [23:0] dlog,
  output logic [30:0]        frac
);

  logic signed [39:0] prod_a;
  logic signed [39:0] ysum;
  logic signed [15:0] n_b;

  logic [30:0] m_e   [17];
  logic [15:0] r_e   [17];
  logic [5:0]  sh_e  [17];
  logic        ovf_e [17];
  logic        udf_e [17];

  logic [61:0] dvs   [32];
  logic [61:0] rem   [32];
  logic [30:0] quo   [32];
  logic        ovf_d [32];
  logic        udf_d [32];

  logic [5:0]  nsh;
  logic [60:0] pw;

  assign ysum = prod_a + 40'sd128;
  assign n_b  = ysum[39:24];

  always_ff @(posedge clk) begin
    prod_a   <= steep * dlog;
    m_e[0]   <= 31'h4000_0000;
    r_e[0]   <= ysum[23:8];
    sh_e[0]  <= n_b[5:0];
    ovf_e[0] <= (n_b >= 16'sd31);
    udf_e[0] <= (n_b < -16'sd31);
  end

  for (genvar k = 0; k < 16; k++) begin : g_exp
    localparam logic [30:0] ROOT = exp_root(k);
    logic [61:0] pr;
    assign pr = 62'(m_e[k]) * 62'(ROOT);
    always_ff @(posedge clk) begin
      m_e[k+1]   <= r_e[k][15-k] ? pr[60:30] : m_e[k];
      r_e[k+1]   <= r_e[k];
      sh_e[k+1]  <= sh_e[k];
      ovf_e[k+1] <= ovf_e[k];
      udf_e[k+1] <= udf_e[k];
    end
  end

  always_comb begin
    nsh = 6'(-sh_e[16]);
    if (sh_e[16][5]) begin
      pw = 61'(m_e[16] >> nsh);
    end else begin
      pw = 61'(m_e[16]) << sh_e[16][4:0];
    end
  end

  always_ff @(posedge clk) begin
    dvs[0]   <= 62'(pw) + 62'h4000_0000;
    rem[0]   <= 62'h2000_0000;
    quo[0]   <= '0;
    ovf_d[0] <= ovf_e[16];
    udf_d[0] <= udf_e[16];
  end

  for (genvar i = 0; i < 31; i++) begin : g_div
    logic [62:0] t;
    assign t = {rem[i], 1'b0};
    always_ff @(posedge clk) begin
      dvs[i+1]   <= dvs[i];
      ovf_d[i+1] <= ovf_d[i];
      udf_d[i+1] <= udf_d[i];
      if (t >= {1'b0, dvs[i]}) begin
        rem[i+1] <= 62'(t - {1'b0, dvs[i]});
        quo[i+1] <= {quo[i][29:0], 1'b1};
      end else begin
        rem[i+1] <= t[61:0];
        quo[i+1] <= {quo[i][29:0], 1'b0};
      end
    end
  end

  always_comb begin
    priority if (ovf_d[31]) begin
      frac = '0;
    end else if (udf_d[31]) begin
      frac = 31'h4000_0000;
    end else begin
      frac = quo[31];
    end
  end

endmodule

@@ rtl/double_logistic_temperature_effect_core.sv @@
// Double-logistic temperature effect core, top level.
// Channels: command input (start, busy, in_beat); result strobe (done, result).
// Each accepted beat gives exactly one result beat, in the order accepted.
// done is high for a single cycle per result beat.
// Throughput: one beat per cycle. busy is always low; the pipeline never
// holds, since every stage advances each cycle.
// Latency is set by the log2 normalize and squaring chain (17 stages), one log
// difference stage, the exponent and restoring divide chain of the fraction
// unit (50 stages) and four stages of factor, product and rounding arithmetic.
// Reset clears the valid chain; beats in flight are dropped and no result
// is given for them. The receiver cannot stall: a result is taken in the
// cycle done is high.
// Status 1 marks a zero midpoint (or nonpositive Kelvin temperature); the
// effect is then 0.
// Depends on dlte_pkg, dlte_log2, dlte_frac.
module double_logistic_temperature_effect_core import dlte_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  dlte_in_t  in_beat,
  output logic      done,
  output dlte_out_t result
);

  logic                accept;
  logic [PIPE_LAT-1:0] vld;
  logic signed [17:0]  tk;
  logic                bad_in;

  logic [20:0] lg_t;
  logic [20:0] lg_lo;
  logic [20:0] lg_hi;

  logic signed [23:0] d_lo;
  logic signed [23:0] d_hi;
  logic [30:0]        f_lo;
  logic [30:0]        f_hi;

  logic signed [15:0] cl_d  [COEF_LAT];
  logic signed [15:0] ch_d  [COEF_LAT];
  logic signed [15:0] al_d  [FLOOR_LAT];
  logic signed [15:0] ah_d  [FLOOR_LAT];
  logic [5:0]         sp_d  [TAG_LAT];
  logic               st_d  [TAG_LAT];

  logic signed [31:0] big_lo;
  logic signed [31:0] big_hi;
  logic signed [32:0] oma_lo;
  logic signed [32:0] oma_hi;
  logic signed [64:0] fm_lo;
  logic signed [64:0] fm_hi;
  logic signed [31:0] a_lo;
  logic signed [31:0] a_hi;
  logic signed [33:0] fac_lo;
  logic signed [33:0] fac_hi;
  logic signed [67:0] prod;
  logic signed [67:0] rsum;
  logic [22:0]        eff_raw;
  logic [15:0]        eff;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign done   = vld[PIPE_LAT-1];

  assign tk     = 18'(in_beat.temperature_c) + KELVIN_Q8;
  assign bad_in = (tk <= 18'sd0) || (in_beat.low_midpoint == '0) ||
                  (in_beat.high_midpoint == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_LAT-2:0], accept};
    end
  end

  dlte_log2 u_log_t  (.clk(clk), .v(tk[16:0]),                     .lg(lg_t));
  dlte_log2 u_log_lo (.clk(clk), .v({1'b0, in_beat.low_midpoint}),  .lg(lg_lo));
  dlte_log2 u_log_hi (.clk(clk), .v({1'b0, in_beat.high_midpoint}), .lg(lg_hi));

  always_ff @(posedge clk) begin
    d_lo <= 24'(lg_lo) - 24'(lg_t) + 24'sd131072;
    d_hi <= 24'(lg_t) - 24'(lg_hi) - 24'sd131072;
  end

  // delay lines for coefficients and tag
  always_ff @(posedge clk) begin
    cl_d[0] <= in_beat.low_steepness;
    ch_d[0] <= in_beat.high_steepness;
    al_d[0] <= in_beat.low_floor;
    ah_d[0] <= in_beat.high_floor;
    sp_d[0] <= in_beat.species_index;
    st_d[0] <= bad_in;
    for (int i = 1; i < COEF_LAT; i++) begin
      cl_d[i] <= cl_d[i-1];
      ch_d[i] <= ch_d[i-1];
    end
    for (int i = 1; i < FLOOR_LAT; i++) begin
      al_d[i] <= al_d[i-1];
      ah_d[i] <= ah_d[i-1];
    end
    for (int i = 1; i < TAG_LAT; i++) begin
      sp_d[i] <= sp_d[i-1];
      st_d[i] <= st_d[i-1];
    end
  end

  dlte_frac u_frac_lo (.clk(clk), .steep(cl_d[COEF_LAT-1]), .dlog(d_lo), .frac(f_lo));
  dlte_frac u_frac_hi (.clk(clk), .steep(ch_d[COEF_LAT-1]), .dlog(d_hi), .frac(f_hi));

  assign big_lo = {al_d[FLOOR_LAT-1], 16'b0};
  assign big_hi = {ah_d[FLOOR_LAT-1], 16'b0};
  assign oma_lo = 33'sh0_4000_0000 - 33'(big_lo);
  assign oma_hi = 33'sh0_4000_0000 - 33'(big_hi);

  always_ff @(posedge clk) begin
    fm_lo  <= 65'(oma_lo) * 65'(signed'({1'b0, f_lo}));
    fm_hi  <= 65'(oma_hi) * 65'(signed'({1'b0, f_hi}));
    a_lo   <= big_lo;
    a_hi   <= big_hi;
    fac_lo <= 34'(a_lo) + 34'(fm_lo >>> 30);
    fac_hi <= 34'(a_hi) + 34'(fm_hi >>> 30);
    prod   <= 68'(fac_lo) * 68'(fac_hi);
  end

  always_comb begin
    rsum    = prod + (68'sd1 <<< 44);
    eff_raw = 23'(rsum >>> 45);
    priority if (prod <= 68'sd0) begin
      eff = '0;
    end else if (eff_raw > 23'(EFFECT_MAX)) begin
      eff = EFFECT_MAX;
    end else begin
      eff = eff_raw[15:0];
    end
  end

  always_ff @(posedge clk) begin
    result.effect      <= st_d[TAG_LAT-1] ? 16'd0 : eff;
    result.species_out <= sp_d[TAG_LAT-1];
    result.status      <= st_d[TAG_LAT-1];
  end

endmodule

@@ rtl/dlte_checker.sv @@
// Port-level checker for the double-logistic temperature effect core.
// Bound to the top level below. Uses dlte_pkg.
module dlte_checker import dlte_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input logic      done,
  input dlte_out_t result
);

  a_done_has_beat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT))
    else $error("result beat without an accepted input beat");

  a_beat_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LAT done)
    else $error("accepted beat gave no result");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status) |-> (result.effect == 16'd0))
    else $error("invalid beat with nonzero effect");

  a_effect_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.effect <= EFFECT_MAX))
    else $error("effect above 1.0");

endmodule

bind double_logistic_temperature_effect_core dlte_checker u_dlte_checker (.*);

@@ tb/sv/tb_double_logistic_temperature_effect_core.sv @@
// Testbench for double_logistic_temperature_effect_core.
// Drives temperature and coefficient beats, predicts each effect with a
// fixed-point model of its own, and checks the result strobe. Needs dlte_pkg.
`timescale 1ns / 100ps

module tb_double_logistic_temperature_effect_core;
  import dlte_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 120;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  dlte_in_t  in_beat;
  logic      done;
  dlte_out_t result;

  dlte_in_t  pending_beats[$];
  dlte_out_t expected_effects[$];
  int        mismatch_count;
  int        idle_cycles;
  logic      feed_done;
  logic      hold_for_drain;
  logic      drain_seen;
  int        drain_index;
  logic [63:0] exp_roots[16];

  double_logistic_temperature_effect_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .in_beat(in_beat),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_m;
    logic [63:0] rem;
    res   = '0;
    rem   = v;
    bit_m = 64'h4000_0000_0000_0000;
    while (bit_m != 0) begin
      if (rem >= res + bit_m) begin
        rem = rem - (res + bit_m);
        res = (res >> 1) + bit_m;
      end else begin
        res = res >> 1;
      end
      bit_m = bit_m >> 2;
    end
    return res;
  endfunction

  function automatic longint floor_shift(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint log2_q16(input logic [31:0] v);
    int          top;
    logic [63:0] mant;
    longint      frac;
    top  = 31;
    frac = 0;
    while (top > 0 && v[top] == 1'b0) top--;
    mant = 64'(v) << (31 - top);
    for (int i = 0; i < 16; i++) begin
      mant = (mant * mant) >> 31;
      frac = frac << 1;
      if (mant >= 64'h1_0000_0000) begin
        mant = mant >> 1;
        frac = frac | 1;
      end
    end
    return longint'(top) * 65536 + frac;
  endfunction

  function automatic longint logistic_fraction(input logic signed [15:0] steep, input longint d);
    longint      y;
    longint      n;
    logic [15:0] r;
    logic [63:0] m;
    logic [63:0] p;
    y = floor_shift(longint'(steep) * d + 128, 8);
    n = floor_shift(y, 16);
    r = y[15:0];
    m = 64'd1 << 30;
    if (n >= 31) return 0;
    if (n < -31) return longint'(1) << 30;
    for (int k = 0; k < 16; k++) begin
      if (r[15 - k]) m = (m * exp_roots[k]) >> 30;
    end
    p = (n >= 0) ? (m << n) : (m >> (-n));
    return longint'((64'd1 << 60) / ((64'd1 << 30) + p));
  endfunction

  function automatic longint side_factor(input logic signed [15:0] floor_q, input longint f);
    longint big_a;
    big_a = longint'(floor_q) * 65536;
    return big_a + floor_shift(((longint'(1) << 30) - big_a) * f, 30);
  endfunction

  function automatic dlte_out_t predict_effect(input dlte_in_t b);
    dlte_out_t o;
    longint    tk;
    longint    lt;
    longint    f_lo;
    longint    f_hi;
    longint    prod;
    longint    eff;
    o.species_out = b.species_index;
    tk = longint'(b.temperature_c) + 69926;
    if (tk <= 0 || b.low_midpoint == 0 || b.high_midpoint == 0) begin
      o.effect = '0;
      o.status = 1'b1;
      return o;
    end
    lt   = log2_q16(32'(tk));
    f_lo = side_factor(b.low_floor, logistic_fraction(b.low_steepness,
             log2_q16(32'(b.low_midpoint)) - lt + 2 * 65536));
    f_hi = side_factor(b.high_floor, logistic_fraction(b.high_steepness,
             lt - log2_q16(32'(b.high_midpoint)) - 2 * 65536));
    prod = f_lo * f_hi;
    if (prod <= 0) begin
      eff = 0;
    end else begin
      eff = (prod + (longint'(1) << 44)) >>> 45;
      if (eff > 32768) eff = 32768;
    end
    o.effect = eff[15:0];
    o.status = 1'b0;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  function automatic dlte_in_t random_beat();
    dlte_in_t b;
    b.temperature_c  = 16'($urandom_range(0, 4) == 0 ?
                         int'($urandom_range(0, 51200)) - 25600 :
                         int'($urandom_range(0, 12800)) - 5120);
    b.species_index  = 6'($urandom);
    b.low_floor      = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 16384));
    b.high_floor     = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 16384));
    b.low_midpoint   = $urandom_range(0, 3) == 0 ? 16'($urandom) :
                         16'($urandom_range(14000, 20000));
    b.high_midpoint  = $urandom_range(0, 3) == 0 ? 16'($urandom) :
                         16'($urandom_range(16000, 22000));
    b.low_steepness  = $urandom_range(0, 3) == 0 ? 16'($urandom) :
                         16'(int'($urandom_range(0, 12800)) - 6400);
    b.high_steepness = $urandom_range(0, 3) == 0 ? 16'($urandom) :
                         16'(int'($urandom_range(0, 12800)) - 6400);
    if ($urandom_range(0, 40) == 0) b.low_midpoint = '0;
    if ($urandom_range(0, 40) == 0) b.high_midpoint = '0;
    return b;
  endfunction

  initial begin
    dlte_in_t b;
    for (int k = 0; k < 16; k++) begin
      exp_roots[k] = (k == 0) ? int_sqrt(64'd1 << 61) : int_sqrt(exp_roots[k - 1] << 30);
    end
    // nominal temperate species
    b = '{temperature_c: 16'sd2560, species_index: 6'd5, low_floor: 16'sd0,
          low_midpoint: 16'd17920, low_steepness: 16'sd5120, high_floor: 16'sd0,
          high_midpoint: 16'd19200, high_steepness: 16'sd5120};
    pending_beats.push_back(b);
    b.temperature_c = 16'sh8000;       pending_beats.push_back(b);
    b.temperature_c = 16'sh7fff;       pending_beats.push_back(b);
    b.temperature_c = -16'sd25600;     pending_beats.push_back(b);
    b.temperature_c = 16'sd25600;      pending_beats.push_back(b);
    b.temperature_c = 16'sd2560;
    b.low_midpoint = '0;               pending_beats.push_back(b);
    b.low_midpoint = 16'd17920;
    b.high_midpoint = '0;              pending_beats.push_back(b);
    b.high_midpoint = 16'hffff;        pending_beats.push_back(b);
    b.low_midpoint = 16'hffff;         pending_beats.push_back(b);
    b.low_midpoint = 16'd1;
    b.high_midpoint = 16'd1;           pending_beats.push_back(b);
    b.low_steepness = 16'sh7fff;
    b.high_steepness = 16'sh7fff;      pending_beats.push_back(b);
    b.low_steepness = 16'sh8000;
    b.high_steepness = 16'sh8000;      pending_beats.push_back(b);
    b.low_floor = 16'sh7fff;
    b.high_floor = 16'sh7fff;          pending_beats.push_back(b);
    b.low_floor = 16'sh8000;           pending_beats.push_back(b);
    b.high_floor = 16'sh8000;          pending_beats.push_back(b);
    b.low_floor = 16'sd16384;
    b.high_floor = 16'sd16384;
    b.species_index = 6'h3f;           pending_beats.push_back(b);
    b.species_index = 6'h00;
    b.low_steepness = '0;
    b.high_steepness = '0;             pending_beats.push_back(b);
    for (int i = 0; i < 650; i++) pending_beats.push_back(random_beat());
  end

  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start          <= 1'b0;
      in_beat        <= '0;
      feed_done      <= 1'b0;
      hold_for_drain <= 1'b0;
      drain_seen     <= 1'b0;
      drain_index    <= 0;
    end else begin
      if (start && !busy) begin
        expected_effects.push_back(predict_effect(in_beat));
        drain_index <= drain_index + 1;
      end
      if (!drain_seen && drain_index >= 300) begin
        hold_for_drain <= 1'b1;
        drain_seen     <= 1'b1;
      end
      if (start && busy) begin
        // hold beat
      end else if (hold_for_drain) begin
        start <= 1'b0;
        if (expected_effects.size() == 0) hold_for_drain <= 1'b0;
      end else if (pending_beats.size() != 0 &&
                   (drain_index < 100 || $urandom_range(0, 99) >= 22)) begin
        start   <= 1'b1;
        in_beat <= pending_beats.pop_front();
      end else begin
        start <= 1'b0;
        if (pending_beats.size() == 0) feed_done <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    dlte_out_t want;
    if (!rst && done) begin
      if (expected_effects.size() == 0) begin
        report_mismatch("unexpected result beat, effect", result.effect, 0);
      end else begin
        want = expected_effects.pop_front();
        if (result.effect !== want.effect)
          report_mismatch("effect", result.effect, want.effect);
        if (result.species_out !== want.species_out)
          report_mismatch("species_out", result.species_out, want.species_out);
        if (result.status !== want.status)
          report_mismatch("status", result.status, want.status);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    mismatch_count = 0;
    idle_cycles    = 0;
    start          = 1'b0;
    in_beat        = '0;
    fork
      begin
        wait (!rst);
        wait (feed_done && !start && expected_effects.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
          $display("double_logistic_temperature_effect_core verification clean");
        end else begin
          $display("double_logistic_temperature_effect_core verification failed");
        end
        $finish;
      end
      begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("TIMEOUT no beat moved in %0d cycles", WATCHDOG_LIMIT);
        $display("double_logistic_temperature_effect_core verification failed");
        $finish;
      end
    join
  end

endmodule
